@@ src/assert_macros.svh @@
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/psu_pkg.sv @@
package psu_pkg;

  // sizes
  localparam int MAX_LINE_BYTES = 16384;
  localparam int MAX_BPP        = 8;
  localparam int LINE_W         = $clog2(MAX_LINE_BYTES);
  localparam int CNT_W          = LINE_W + 1;
  localparam int LEN_W          = 15;
  localparam int BPP_W          = 4;
  localparam int CMP_W          = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SLOT_W         = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int WIN_DEPTH      = 2 ** SLOT_W;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  // configuration port
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam logic REG_LINE_BYTES = 1'b0;
  localparam logic REG_BPP        = 1'b1;

  // row filter codes, invalid types collapse to FILT_BAD
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_e;

  // one classified data byte
  typedef struct packed {
    logic [7:0]        fbyte;
    filt_e             filt;
    logic [LINE_W-1:0] col;
    logic              first_row;
    logic              last;
    logic              use_left;
    logic [SLOT_W-1:0] back;
  } item_t;

  // queue status
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // back end status
  typedef struct packed {
    logic e_valid;
    logic e_fire;
  } bstat_t;

  // paeth predictor, ties go a, then b, then c
  function automatic logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic signed [10:0] sa;
    logic signed [10:0] sb;
    logic signed [10:0] sc;
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [7:0]         r;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    p  = sa + sb - sc;
    da = p - sa;
    db = p - sb;
    dc = p - sc;
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    if (pa <= pb && pa <= pc) begin
      r = a;
    end else if (pb <= pc) begin
      r = b;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

@@ src/psu_front.sv @@
module psu_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [7:0]                 filtered_byte_i,
  input  logic                       image_start_i,
  input  logic [psu_pkg::LEN_W-1:0]  line_bytes_i,
  input  logic [psu_pkg::BPP_W-1:0]  bytes_per_pixel_i,
  input  psu_pkg::qstat_t            q_stat_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output psu_pkg::item_t             item_o
);

  logic [psu_pkg::CNT_W-1:0] column_q, column_d;
  psu_pkg::filt_e            filt_q, filt_d;
  logic                      first_row_q, first_row_d;

  logic [psu_pkg::CNT_W-1:0] col_start;
  logic                      first_cur;
  logic [psu_pkg::CMP_W-1:0] len_w;
  logic [psu_pkg::CNT_W-1:0] len_eff;
  logic [psu_pkg::BPP_W-1:0] bpp_eff;
  logic [psu_pkg::CNT_W-1:0] col_raw;
  logic [psu_pkg::CNT_W-1:0] col_c;
  logic [psu_pkg::CNT_W-1:0] back_w;
  logic                      is_filter;
  logic                      is_last;
  logic                      accept;

  // input stalls only on a full queue
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;

  // clamp configuration to the supported range
  always_comb begin
    len_w = psu_pkg::CMP_W'(line_bytes_i);
    if (len_w == '0) begin
      len_w = psu_pkg::CMP_W'(1);
    end else if (len_w > psu_pkg::CMP_W'(psu_pkg::MAX_LINE_BYTES)) begin
      len_w = psu_pkg::CMP_W'(psu_pkg::MAX_LINE_BYTES);
    end
    len_eff = psu_pkg::CNT_W'(len_w);
    bpp_eff = bytes_per_pixel_i;
    if (bpp_eff == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bpp_eff > psu_pkg::BPP_W'(psu_pkg::MAX_BPP)) begin
      bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_BPP);
    end
  end

  // column tracking and classification
  always_comb begin
    col_start = image_start_i ? '0 : column_q;
    first_cur = image_start_i | first_row_q;
    is_filter = (col_start == '0);
    col_raw   = col_start - psu_pkg::CNT_W'(1);
    col_c     = (col_raw >= len_eff) ? (len_eff - psu_pkg::CNT_W'(1)) : col_raw;
    is_last   = (col_c == len_eff - psu_pkg::CNT_W'(1));
    back_w    = col_c - psu_pkg::CNT_W'(bpp_eff);

    item_o.fbyte     = filtered_byte_i;
    item_o.filt      = filt_q;
    item_o.col       = col_c[psu_pkg::LINE_W-1:0];
    item_o.first_row = first_cur;
    item_o.last      = is_last;
    item_o.use_left  = (col_c >= psu_pkg::CNT_W'(bpp_eff));
    item_o.back      = back_w[psu_pkg::SLOT_W-1:0];

    push_o = accept & ~is_filter;

    column_d    = column_q;
    filt_d      = filt_q;
    first_row_d = first_row_q;
    if (accept) begin
      if (is_filter) begin
        filt_d      = (filtered_byte_i <= 8'd4) ? psu_pkg::filt_e'(filtered_byte_i[2:0])
                                                : psu_pkg::FILT_BAD;
        column_d    = psu_pkg::CNT_W'(1);
        first_row_d = first_cur;
      end else if (is_last) begin
        column_d    = '0;
        first_row_d = 1'b0;
      end else begin
        column_d    = col_c + psu_pkg::CNT_W'(2);
        first_row_d = first_cur;
      end
    end
  end

  // front state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      filt_q      <= psu_pkg::FILT_NONE;
      first_row_q <= 1'b1;
    end else begin
      column_q    <= column_d;
      filt_q      <= filt_d;
      first_row_q <= first_row_d;
    end
  end

endmodule

@@ src/psu_fifo.sv @@
module psu_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psu_pkg::item_t  item_i,
  input  logic            pop_i,
  output psu_pkg::item_t  item_o,
  output psu_pkg::qstat_t stat_o
);

  psu_pkg::item_t             entries_q [psu_pkg::QDEPTH];
  logic [psu_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [psu_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [psu_pkg::QCNT_W-1:0] count_q, count_d;

  // status and head
  assign stat_o.full  = (count_q == psu_pkg::QCNT_W'(psu_pkg::QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;
  assign item_o       = entries_q[rd_ptr_q];

  // pointer update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + psu_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + psu_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + psu_pkg::QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - psu_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/psu_back.sv @@
module psu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psu_pkg::item_t  head_i,
  input  psu_pkg::qstat_t q_stat_i,
  output logic            pop_o,
  output psu_pkg::bstat_t stat_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      pixel_byte_o,
  output logic            line_end_o,
  output logic            bad_filter_o
);

  // previous row, one read and one write port
  logic [7:0] line_mem [psu_pkg::MAX_LINE_BYTES];

  logic [7:0] left_win_q [psu_pkg::WIN_DEPTH];
  logic [7:0] upl_win_q  [psu_pkg::WIN_DEPTH];

  logic           e_valid_q, e_valid_d;
  psu_pkg::item_t e_item_q;
  logic [7:0]     up_q;

  logic       out_valid_q, out_valid_d;
  logic [7:0] pixel_q;
  logic       line_end_q;
  logic       bad_q;

  logic       e_fire;
  logic       load;
  logic       fwd;
  logic [7:0] a, b, c;
  logic [8:0] sum_ab;
  logic [7:0] pred;
  logic [7:0] raw;
  logic       bad;

  // stage handshake
  assign e_fire      = e_valid_q & ~(out_valid_q & out_stall_i);
  assign load        = ~q_stat_i.empty & (~e_valid_q | e_fire);
  assign pop_o       = load;
  assign e_valid_d   = load | (e_valid_q & ~e_fire);
  assign out_valid_d = e_fire | (out_valid_q & out_stall_i);
  assign fwd         = e_fire & (e_item_q.col == head_i.col);

  assign stat_o.e_valid = e_valid_q;
  assign stat_o.e_fire  = e_fire;

  // neighbors and reconstruction
  always_comb begin
    b      = e_item_q.first_row ? 8'd0 : up_q;
    a      = e_item_q.use_left ? left_win_q[e_item_q.back] : 8'd0;
    c      = e_item_q.use_left ? upl_win_q[e_item_q.back] : 8'd0;
    sum_ab = {1'b0, a} + {1'b0, b};
    bad    = 1'b0;
    unique case (e_item_q.filt)
      psu_pkg::FILT_NONE:  pred = 8'd0;
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
      default: begin
        pred = 8'd0;
        bad  = 1'b1;
      end
    endcase
    raw = e_item_q.fbyte + pred;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      e_valid_q   <= e_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stage payload and line store
  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      line_mem[e_item_q.col] <= raw;
    end
    if (load) begin
      e_item_q <= head_i;
      up_q     <= fwd ? raw : line_mem[head_i.col];
    end
  end

  // row windows
  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      left_win_q[e_item_q.col[psu_pkg::SLOT_W-1:0]] <= raw;
      upl_win_q[e_item_q.col[psu_pkg::SLOT_W-1:0]]  <= b;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      pixel_q    <= raw;
      line_end_q <= e_item_q.last;
      bad_q      <= bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign line_end_o   = line_end_q;
  assign bad_filter_o = bad_q;

endmodule

@@ src/png_scanline_unfilter.sv @@
// PNG scanline reconstruction (filter types None, Sub, Up, Average, Paeth). Takes the inflated
// stream one byte per beat; the first byte of each row is the filter type and gives no result,
// each following data byte gives one raw byte, with line_end on the last byte of the row and
// bad_filter on every byte of a row whose filter type is above 4. Sustained rate is one byte per
// clock while out_stall is low, set by the single-read, single-write line store of the previous row;
// image_start on a byte restarts the image there. The user writes line_bytes (address 0) and
// bytes_per_pixel (address 4) only while no beats are in flight; the block does not enforce it.
`include "assert_macros.svh"

module png_scanline_unfilter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psu_pkg::ADDR_W-1:0]  paddr,
  input  logic [psu_pkg::DATA_W-1:0]  pwdata,
  output logic [psu_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // filtered stream
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  filtered_byte_i,
  input  logic                        image_start_i,
  // raw bytes
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  pixel_byte_o,
  output logic                        line_end_o,
  output logic                        bad_filter_o
);

  logic [psu_pkg::LEN_W-1:0] line_bytes_q;
  logic [psu_pkg::BPP_W-1:0] bpp_q;
  logic                      cfg_wr;

  logic            q_push;
  logic            q_pop;
  psu_pkg::item_t  q_in;
  psu_pkg::item_t  q_head;
  psu_pkg::qstat_t q_stat;
  psu_pkg::bstat_t b_stat;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= psu_pkg::LEN_W'(1);
      bpp_q        <= psu_pkg::BPP_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == psu_pkg::REG_LINE_BYTES) begin
        line_bytes_q <= pwdata[psu_pkg::LEN_W-1:0];
      end else begin
        bpp_q <= pwdata[psu_pkg::BPP_W-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr[2] == psu_pkg::REG_BPP) begin
      prdata[psu_pkg::BPP_W-1:0] = bpp_q;
    end else begin
      prdata[psu_pkg::LEN_W-1:0] = line_bytes_q;
    end
  end

  psu_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .filtered_byte_i   (filtered_byte_i),
    .image_start_i     (image_start_i),
    .line_bytes_i      (line_bytes_q),
    .bytes_per_pixel_i (bpp_q),
    .q_stat_i          (q_stat),
    .in_stall_o        (in_stall_o),
    .push_o            (q_push),
    .item_o            (q_in)
  );

  psu_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_head),
    .stat_o (q_stat)
  );

  psu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .q_stat_i     (q_stat),
    .pop_o        (q_pop),
    .stat_o       (b_stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_byte_o (pixel_byte_o),
    .line_end_o   (line_end_o),
    .bad_filter_o (bad_filter_o)
  );

  // checks
  `ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, q_pop, !q_stat.empty)
  `ASSERT_NEXT(a_q_count_up, clk_i, rst_ni, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)
  `ASSERT_IMPL(a_fire_free_out, clk_i, rst_ni, b_stat.e_fire, !(out_valid_o && out_stall_i))

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 2000;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int SETTLE      = 8;

  // one raw byte as it leaves the block
  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
    logic       bad_filter;
  } raw_beat_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [psu_pkg::ADDR_W-1:0] paddr           = '0;
  logic [psu_pkg::DATA_W-1:0] pwdata          = '0;
  logic [psu_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 filtered_byte_i = 8'h00;
  logic                       image_start_i   = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic [7:0]                 pixel_byte_o;
  logic                       line_end_o;
  logic                       bad_filter_o;

  png_scanline_unfilter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .filtered_byte_i (filtered_byte_i),
    .image_start_i   (image_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_byte_o    (pixel_byte_o),
    .line_end_o      (line_end_o),
    .bad_filter_o    (bad_filter_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the block state
  logic [7:0]      up_row [psu_pkg::MAX_LINE_BYTES];
  logic [7:0]      left_win [psu_pkg::MAX_BPP];
  logic [7:0]      upleft_win [psu_pkg::MAX_BPP];
  int unsigned     col_pos     = 0;
  psu_pkg::filt_e  row_filt    = psu_pkg::FILT_NONE;
  logic            first_row_q = 1'b1;
  logic [14:0]     line_cfg    = 15'd1;
  logic [3:0]      bpp_cfg     = 4'd1;
  // columns of the line store written since reset, always a prefix
  int unsigned     stored_len  = 0;

  raw_beat_t   pending_raw [$];

  int err_cnt       = 0;
  int items_sent    = 0;
  int beats_checked = 0;
  int rows_seen     = 0;
  int bad_rows      = 0;
  int images_seen   = 0;
  int cfg_writes    = 0;
  int send_gap_pct  = 0;
  int stall_gap_pct = 0;
  int stall_left    = 0;
  int cycle_cnt     = 0;

  function automatic int unsigned row_len();
    if (line_cfg == 15'd0) return 1;
    if (line_cfg > psu_pkg::MAX_LINE_BYTES) return psu_pkg::MAX_LINE_BYTES;
    return line_cfg;
  endfunction

  function automatic int unsigned pixel_len();
    if (bpp_cfg == 4'd0) return 1;
    if (bpp_cfg > psu_pkg::MAX_BPP) return psu_pkg::MAX_BPP;
    return bpp_cfg;
  endfunction

  // nearest of a, b, c to a+b-c, ties in order a, b, c
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // advance the predicted state by one accepted byte, queue its raw beat
  function automatic void unfilter_byte(input logic [7:0] fb, input logic img);
    int unsigned len;
    int unsigned bpp;
    int unsigned col;
    int unsigned slot;
    int unsigned back;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  raw;
    logic        bad;
    raw_beat_t   beat;
    len = row_len();
    bpp = pixel_len();
    if (img) begin
      first_row_q = 1'b1;
      col_pos     = 0;
      left_win    = '{default: 8'h00};
      upleft_win  = '{default: 8'h00};
      images_seen++;
    end
    // filter type byte, nothing comes out
    if (col_pos == 0) begin
      row_filt = (fb <= 8'(psu_pkg::FILT_PAETH)) ? psu_pkg::filt_e'(fb[2:0])
                                                  : psu_pkg::FILT_BAD;
      col_pos  = 1;
      rows_seen++;
      if (row_filt == psu_pkg::FILT_BAD) bad_rows++;
      return;
    end
    // a shrunk line length ends the row on this byte
    col  = col_pos - 1;
    if (col >= len) col = len - 1;
    slot = col % psu_pkg::MAX_BPP;
    b    = first_row_q ? 8'h00 : up_row[col];
    if (col >= bpp) begin
      back = (col - bpp) % psu_pkg::MAX_BPP;
      a    = left_win[back];
      c    = upleft_win[back];
    end else begin
      a = 8'h00;
      c = 8'h00;
    end
    bad = 1'b0;
    case (row_filt)
      psu_pkg::FILT_NONE:  raw = fb;
      psu_pkg::FILT_SUB:   raw = fb + a;
      psu_pkg::FILT_UP:    raw = fb + b;
      psu_pkg::FILT_AVG:   raw = fb + 8'((9'(a) + 9'(b)) >> 1);
      psu_pkg::FILT_PAETH: raw = fb + paeth_pick(a, b, c);
      default: begin
        raw = fb;
        bad = 1'b1;
      end
    endcase
    left_win[slot]   = raw;
    upleft_win[slot] = b;
    up_row[col]      = raw;
    if (col + 1 > stored_len) stored_len = col + 1;
    beat.pixel      = raw;
    beat.bad_filter = bad;
    beat.line_end   = (col + 1 >= len);
    if (beat.line_end) begin
      col_pos     = 0;
      first_row_q = 1'b0;
    end else begin
      col_pos = col + 2;
    end
    pending_raw = {pending_raw, beat};
  endfunction

  // idle length: mostly none or short, sometimes long
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // one beat into the block; valid is left high for a back-to-back follow-up
  task automatic send_byte(input logic [7:0] fb, input logic img);
    int gap;
    gap = pick_gap(send_gap_pct);
    // never let a later row read an unwritten line store column
    if (!img && col_pos != 0 && !first_row_q &&
        ((col_pos - 1 < row_len()) ? col_pos - 1 : row_len() - 1) >= stored_len) begin
      img = 1'b1;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    filtered_byte_i <= fb;
    image_start_i   <= img;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    unfilter_byte(fb, img);
    items_sent++;
  endtask

  // stop sending and wait until every raw beat is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_raw.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register write, setup then access
  task automatic apb_write(input logic idx, input logic [psu_pkg::DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == psu_pkg::REG_LINE_BYTES) line_cfg = val[14:0];
    else bpp_cfg = val[3:0];
    cfg_writes++;
  endtask

  // filter byte then a full row of random data, optionally cut by an image start
  task automatic send_row(input logic [7:0] ftype, input logic img, input bit noisy);
    int unsigned n;
    int unsigned cut;
    int unsigned i;
    n = row_len();
    if (col_pos != 0 || (!first_row_q && n > stored_len)) img = 1'b1;
    cut = noisy ? $urandom_range(n) : 0;
    send_byte(ftype, img);
    for (i = 1; i <= n; i++) send_byte(8'($urandom_range(255)), i == cut);
  endtask

  // every filter type once, with data extremes
  task automatic test_each_filter();
    logic [7:0] stream [21];
    int i;
    stream = '{8'(psu_pkg::FILT_NONE), 8'h00, 8'hFF,
               8'(psu_pkg::FILT_SUB), 8'hFF, 8'h01,
               8'(psu_pkg::FILT_UP), 8'h80, 8'h7F,
               8'(psu_pkg::FILT_AVG), 8'hFF, 8'hFF,
               8'(psu_pkg::FILT_PAETH), 8'h01, 8'hFE,
               8'(psu_pkg::FILT_BAD), 8'h12, 8'h34,
               8'hFF, 8'hAB, 8'hCD};
    apb_write(psu_pkg::REG_LINE_BYTES, 32'd2);
    apb_write(psu_pkg::REG_BPP, 32'd1);
    for (i = 0; i < 21; i++) send_byte(stream[i], i == 0);
    drain();
  endtask

  // clamped register values: zero and all ones
  task automatic test_length_limits();
    int i;
    apb_write(psu_pkg::REG_LINE_BYTES, 32'd0);
    apb_write(psu_pkg::REG_BPP, 32'd0);
    send_row(8'(psu_pkg::FILT_SUB), 1'b1, 1'b0);
    send_row(8'(psu_pkg::FILT_PAETH), 1'b0, 1'b0);
    send_row(8'(psu_pkg::FILT_AVG), 1'b0, 1'b0);
    drain();
    // widest pixels, a line length far past the bytes sent, then cut to end the row
    send_gap_pct  = 10;
    stall_gap_pct = 10;
    apb_write(psu_pkg::REG_LINE_BYTES, 32'hFFFF_FFFF);
    apb_write(psu_pkg::REG_BPP, 32'hFFFF_FFFF);
    send_byte(8'(psu_pkg::FILT_SUB), 1'b1);
    for (i = 0; i < 150; i++) send_byte(8'($urandom_range(255)), 1'b0);
    drain();
    apb_write(psu_pkg::REG_LINE_BYTES, 32'd151);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_row(8'(psu_pkg::FILT_PAETH), 1'b0, 1'b0);
    drain();
  endtask

  // image start inside a row, then the line length shrinks under the column
  task automatic test_restart_and_shrink();
    int i;
    send_gap_pct  = 30;
    stall_gap_pct = 30;
    apb_write(psu_pkg::REG_LINE_BYTES, 32'd6);
    apb_write(psu_pkg::REG_BPP, 32'd2);
    send_row(8'(psu_pkg::FILT_UP), 1'b1, 1'b0);
    send_byte(8'(psu_pkg::FILT_PAETH), 1'b0);
    for (i = 0; i < 3; i++) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'(psu_pkg::FILT_AVG), 1'b1);
    for (i = 0; i < 2; i++) send_byte(8'($urandom_range(255)), 1'b0);
    drain();
    apb_write(psu_pkg::REG_LINE_BYTES, 32'd2);
    send_byte(8'hC3, 1'b0);
    send_row(8'(psu_pkg::FILT_AVG), 1'b0, 1'b0);
    send_row(8'(psu_pkg::FILT_PAETH), 1'b0, 1'b0);
    drain();
  endtask

  // phases of random settings, mostly well-formed rows
  task automatic test_random_stream();
    int                         start;
    int                         phase_start;
    int                         phase_len;
    int unsigned                len;
    logic [psu_pkg::DATA_W-1:0] hi;
    logic [7:0]                 ftype;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      drain();
      hi = ($urandom_range(3) == 0) ? psu_pkg::DATA_W'($urandom()) : '0;
      case ($urandom_range(19))
        0:       len = 0;
        1, 2:    len = $urandom_range(200, 25);
        default: len = $urandom_range(24, 1);
      endcase
      apb_write(psu_pkg::REG_LINE_BYTES, (hi & ~32'h7FFF) | len);
      if ($urandom_range(4) == 0) begin
        apb_write(psu_pkg::REG_BPP, (hi & ~32'hF) | $urandom_range(15));
      end else begin
        apb_write(psu_pkg::REG_BPP, (hi & ~32'hF) | $urandom_range(8, 1));
      end
      case ($urandom_range(2))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 25;
        default: send_gap_pct = 60;
      endcase
      case ($urandom_range(2))
        0:       stall_gap_pct = 0;
        1:       stall_gap_pct = 25;
        default: stall_gap_pct = 60;
      endcase
      phase_start = items_sent;
      phase_len   = $urandom_range(300, 100);
      while (items_sent - phase_start < phase_len) begin
        if ($urandom_range(9) == 0) ftype = 8'($urandom_range(255, 5));
        else ftype = 8'($urandom_range(4));
        send_row(ftype, $urandom_range(9) == 0, $urandom_range(19) == 0);
      end
    end
  endtask

  // receiver: random stall, check each accepted beat against the oldest prediction
  always @(posedge clk_i) begin : rx_side
    raw_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        beats_checked++;
        if (pending_raw.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected raw beat at %0t: pixel %02h end %0b bad %0b",
                     $realtime, pixel_byte_o, line_end_o, bad_filter_o);
          end
        end else begin
          want = pending_raw.pop_front();
          if (pixel_byte_o !== want.pixel || line_end_o !== want.line_end ||
              bad_filter_o !== want.bad_filter) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch at %0t: expected pixel %02h end %0b bad %0b, got %02h %0b %0b",
                       $realtime, want.pixel, want.line_end, want.bad_filter,
                       pixel_byte_o, line_end_o, bad_filter_o);
            end
          end
        end
      end
      stall_left = (stall_left > 0) ? stall_left - 1 : pick_gap(stall_gap_pct);
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("png_scanline_unfilter test failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_each_filter();
    test_length_limits();
    test_restart_and_shrink();
    test_random_stream();
    drain();
    $display("sent %0d stream bytes: %0d rows, %0d with a bad filter type, %0d image starts",
             items_sent, rows_seen, bad_rows, images_seen);
    $display("checked %0d raw beats over %0d register writes, %0d mismatches",
             beats_checked, cfg_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("png_scanline_unfilter test passed");
    end else begin
      $display("png_scanline_unfilter test failed");
    end
    $finish;
  end

endmodule
